>>> rtl/w3sf_pkg.sv
// ----------------------------------------------------------------------------
// w3sf_pkg
// Shared constants and types for the weighted 3x3 smoothing filter.
// ----------------------------------------------------------------------------
package w3sf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    localparam int PIX_W   = 8;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 16;
    localparam int CNT_W   = 26;
    localparam int CFG_W   = 16;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(640);
    localparam logic [HGT_W-1:0] RESET_HEIGHT = HGT_W'(480);
    localparam logic [CNT_W-1:0] RESET_TOT_M1 = CNT_W'(640 * 480 - 1);
    localparam logic [CNT_W-1:0] RESET_TMW    = CNT_W'(640 * 479);
    localparam logic [WID_W-1:0] MAX_WIDTH_W  = WID_W'(MAX_WIDTH);

    // sum / 10 as (sum * 6554) >> 16, exact for sums below 16384
    localparam int SUM_W       = 12;
    localparam int DIV10_MUL_W = 13;
    localparam int DIV10_SHIFT = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(6554);
    localparam int PROD_W = SUM_W + DIV10_MUL_W;

    // item held in the stage that owns the line store read data
    typedef struct packed {
        logic              vld;
        logic              pix;     // pixel item: writes the line stores
        logic              out;     // gives a result
        logic              filt;    // interior pixel: filtered value
        logic              sel_up;  // flush reads the upper line store
        logic              fe;
        logic [ADDR_W-1:0] col;
        logic [PIX_W-1:0]  px;
    } t_stage;

endpackage

>>> rtl/weighted_3x3_smoothing_filter.sv
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter
// Streams an 8-bit frame in raster order and returns it smoothed by a
// 3x3 kernel (weights 1, center 2, divided by 10); border pixels pass through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): i_action = 0 carries a pixel in
//   i_pixel_in, i_action = 1 is a flush. Output channel (o_out_valid /
//   i_out_stall) carries o_pixel_out and o_frame_end (last pixel of a frame).
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes
//   frame_width (index 0) or frame_height (index 1) and restarts the frame;
//   write only while the block is idle.
//   Each result lags its own pixel by one row plus one pixel
//   (W+1 items); after the last pixel of a frame, W+1 flush items drain the
//   remaining results. Flushes with nothing pending give no result.
//   Throughput is one item per clock while i_out_stall lets the read stage
//   advance. The line stores are read at the accept edge, and the kernel sum
//   and the divide by 10 go into the output register as the item leaves the read stage.
//   Two line stores (1024 x 8) are read at accept and written back as the item
//   leaves the read stage; a read of the entry being written takes the forwarded data.
//   Reset (i_rst_n low, synchronous) sets 640 x 480 and an empty pipe; the
//   line stores keep no reset. When i_out_stall is held, one result waits in
//   the output register, one item waits in the read stage, and o_in_stall
//   rises.
// ----------------------------------------------------------------------------
module weighted_3x3_smoothing_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [w3sf_pkg::PIX_W-1:0] i_pixel_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [w3sf_pkg::PIX_W-1:0] o_pixel_out,
    output logic                       o_frame_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [w3sf_pkg::CFG_W-1:0] i_cfg_data
);
    import w3sf_pkg::*;

    // configuration and derived frame sizes
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [CNT_W-1:0] r_tot_m1;
    logic [CNT_W-1:0] r_tmw;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [WID_W+HGT_W-1:0] tot_full;
    logic [WID_W+HGT_W-1:0] tmw_full;

    // position counters
    logic [ADDR_W-1:0] r_col, n_col;
    logic [HGT_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  r_emit, n_emit;

    // line stores
    logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_q_up, r_q_mid;
    logic [ADDR_W-1:0] rd_up, rd_mid;

    // forwarding of the write that overlaps the read
    logic r_fwd_up, r_fwd_mid;
    logic [PIX_W-1:0] r_fwd_up_d, r_fwd_mid_d;

    // window: columns c-1 and c-2 of top, middle and bottom rows
    logic [PIX_W-1:0] r_win_c1 [3];
    logic [PIX_W-1:0] r_win_c2 [3];

    t_stage r_s, n_s;

    logic r_o_vld;
    logic [PIX_W-1:0] r_o_pix;
    logic r_o_fe;

    logic accept, cfg_wr, s_adv, out_free, wr_en;
    logic pix_restart, produce, filt, flush_ok, flush_up;
    logic [ADDR_W-1:0] c_cur;
    logic [HGT_W-1:0]  r_cur;
    logic [CNT_W-1:0]  emit_cur;
    logic [WID_W-1:0]  c_inc;
    logic [CNT_W-1:0]  flush_off;

    logic [PIX_W-1:0] s_top, s_mid, s_val, quot;
    logic [SUM_W-1:0] s_sum;
    logic [PROD_W-1:0] s_prod;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_width > MAX_WIDTH_W) begin
            w_eff = MAX_WIDTH_W;
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? HGT_W'(1) : r_height;
    end

    assign tot_full = {{HGT_W{1'b0}}, w_eff} * {{WID_W{1'b0}}, h_eff};
    assign tmw_full = {{HGT_W{1'b0}}, w_eff} * {{WID_W{1'b0}}, h_eff - HGT_W'(1)};

    // handshake
    assign out_free   = ~r_o_vld | ~i_out_stall;
    assign s_adv      = r_s.vld & (~r_s.out | out_free);
    assign o_in_stall = r_s.vld & ~s_adv;
    assign accept     = i_in_valid & ~o_in_stall;
    assign wr_en      = s_adv & r_s.pix;

    // accept-time decisions
    always_comb begin
        pix_restart = (r_row >= h_eff) | ({1'b0, r_col} >= w_eff);
        c_cur    = pix_restart ? '0 : r_col;
        r_cur    = pix_restart ? '0 : r_row;
        emit_cur = pix_restart ? '0 : r_emit;
        produce  = (r_cur >= HGT_W'(2)) | ((r_cur == HGT_W'(1)) & (c_cur != '0));
        filt     = (c_cur >= ADDR_W'(2)) & (r_cur >= HGT_W'(2));
        c_inc    = {1'b0, c_cur} + WID_W'(1);
        flush_ok  = (r_row >= h_eff) & (r_emit <= r_tot_m1);
        flush_up  = r_emit < r_tmw;
        flush_off = r_emit - r_tmw;

        n_col  = r_col;
        n_row  = r_row;
        n_emit = r_emit;
        n_s    = r_s;
        rd_up  = c_cur;
        rd_mid = c_cur;
        if (s_adv) begin
            n_s.vld = 1'b0;
        end
        if (i_action) begin
            rd_up  = ADDR_W'(w_eff - WID_W'(1));
            rd_mid = flush_off[ADDR_W-1:0];
        end
        if (cfg_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_emit = '0;
        end else if (accept) begin
            if (!i_action) begin
                if (c_inc == w_eff) begin
                    n_col = '0;
                    n_row = r_cur + HGT_W'(1);
                end else begin
                    n_col = c_inc[ADDR_W-1:0];
                    n_row = r_cur;
                end
                n_emit     = emit_cur + CNT_W'(produce);
                n_s.vld    = 1'b1;
                n_s.pix    = 1'b1;
                n_s.out    = produce;
                n_s.filt   = filt;
                n_s.sel_up = 1'b0;
                n_s.fe     = (emit_cur == r_tot_m1);
                n_s.col    = c_cur;
                n_s.px     = i_pixel_in;
            end else if (flush_ok) begin
                n_emit     = r_emit + CNT_W'(1);
                n_s.vld    = 1'b1;
                n_s.pix    = 1'b0;
                n_s.out    = 1'b1;
                n_s.filt   = 1'b0;
                n_s.sel_up = flush_up;
                n_s.fe     = (r_emit == r_tot_m1);
                n_s.col    = c_cur;
                n_s.px     = i_pixel_in;
            end
        end
    end

    // read stage: store data, with the overlapping write forwarded
    always_comb begin
        s_top = r_fwd_up  ? r_fwd_up_d  : r_q_up;
        s_mid = r_fwd_mid ? r_fwd_mid_d : r_q_mid;
        s_sum = SUM_W'(r_win_c2[0]) + SUM_W'(r_win_c2[1]) + SUM_W'(r_win_c2[2])
              + SUM_W'(r_win_c1[0]) + SUM_W'({r_win_c1[1], 1'b0}) + SUM_W'(r_win_c1[2])
              + SUM_W'(s_top) + SUM_W'(s_mid) + SUM_W'(r_s.px);
        s_prod = {{DIV10_MUL_W{1'b0}}, s_sum} * {{SUM_W{1'b0}}, DIV10_MUL};
        quot   = s_prod[DIV10_SHIFT +: PIX_W];
        if (!r_s.pix) begin
            s_val = r_s.sel_up ? s_top : s_mid;
        end else if (r_s.filt) begin
            s_val = quot;
        end else begin
            s_val = r_win_c1[1];
        end
    end

    // line stores: read at accept, written back as the stage retires
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_up[r_s.col]  <= s_mid;
            mem_mid[r_s.col] <= r_s.px;
        end
        if (accept) begin
            r_q_up  <= mem_up[rd_up];
            r_q_mid <= mem_mid[rd_mid];
            r_fwd_up_d  <= s_mid;
            r_fwd_mid_d <= r_s.px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_up  <= 1'b0;
            r_fwd_mid <= 1'b0;
        end else if (accept) begin
            r_fwd_up  <= wr_en & (rd_up  == r_s.col);
            r_fwd_mid <= wr_en & (rd_mid == r_s.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_tot_m1 <= RESET_TOT_M1;
            r_tmw    <= RESET_TMW;
        end else begin
            if (cfg_wr) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                    default:          r_width  <= r_width;
                endcase
            end
            r_tot_m1 <= CNT_W'(tot_full - (WID_W + HGT_W)'(1));
            r_tmw    <= CNT_W'(tmw_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_emit <= '0;
            r_s    <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_emit <= n_emit;
            r_s    <= n_s;
        end
    end

    // window shift as each pixel retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win_c1[i] <= '0;
                r_win_c2[i] <= '0;
            end
        end else if (wr_en) begin
            for (int i = 0; i < 3; i++) begin
                r_win_c2[i] <= r_win_c1[i];
            end
            r_win_c1[0] <= s_top;
            r_win_c1[1] <= s_mid;
            r_win_c1[2] <= r_s.px;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s_adv && r_s.out) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && r_s.out) begin
            r_o_pix <= s_val;
            r_o_fe  <= r_s.fe;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_pixel_out = r_o_pix;
    assign o_frame_end = r_o_fe;

endmodule
